FILE: hdl/rcd_pkg.sv
package rcd_pkg;

  localparam int unsigned COL_CAP_DEF = 1024;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned COLUMN_W  = 10;
  localparam int unsigned RKIND_W   = 2;
  localparam int unsigned RECNUM_W  = 32;
  localparam int unsigned LEN_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY     = 1'd1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NULL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EOT   = 2'd3;

  // record kinds
  localparam logic [RKIND_W-1:0] RKIND_NORMAL = 2'd0;
  localparam logic [RKIND_W-1:0] RKIND_LOB    = 2'd1;
  localparam logic [RKIND_W-1:0] RKIND_WIDE   = 2'd2;
  localparam logic [RKIND_W-1:0] RKIND_SINGLE = 2'd3;

  // column markers
  localparam logic [BYTE_W-1:0] MRK_NULL  = 8'hFF;
  localparam logic [BYTE_W-1:0] MRK_EMPTY = 8'h00;
  localparam logic [BYTE_W-1:0] MRK_LEN2  = 8'hFE;

  // header bytes
  localparam logic [BYTE_W-1:0] HDR_EOT0    = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_EOT1    = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_NORMAL0 = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_NORMAL1 = 8'h04;
  localparam logic [BYTE_W-1:0] HDR_LOB0    = 8'h08;
  localparam logic [BYTE_W-1:0] HDR_LOB1    = 8'h09;
  localparam logic [BYTE_W-1:0] HDR_WIDE0   = 8'h18;
  localparam logic [BYTE_W-1:0] HDR_WIDE1   = 8'h19;
  localparam logic [BYTE_W-1:0] HDR_WIDE2   = 8'h1C;
  localparam logic [BYTE_W-1:0] HDR_WIDE3   = 8'h2C;
  localparam logic [BYTE_W-1:0] HDR_WIDE4   = 8'h3C;
  localparam logic [BYTE_W-1:0] HDR_SINGLE  = 8'h0C;

  localparam logic [RECNUM_W-1:0] RECNUM_MAX = '1;

endpackage

FILE: hdl/rcd_if.sv
interface rcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [rcd_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [rcd_pkg::KIND_W-1:0]    kind;
  logic [rcd_pkg::COLUMN_W-1:0]  column;
  logic [rcd_pkg::BYTE_W-1:0]    value_byte;
  logic                          column_end;
  logic                          record_end;
  logic [rcd_pkg::RKIND_W-1:0]   record_kind;
  logic [rcd_pkg::RECNUM_W-1:0]  record_number;

  modport source (output valid, output kind, output column, output value_byte,
                  output column_end, output record_end, output record_kind,
                  output record_number, input ready);
  modport sink   (input valid, input kind, input column, input value_byte,
                  input column_end, input record_end, input record_kind,
                  input record_number, output ready);
endinterface

FILE: hdl/record_column_deframer.sv
// channel   dir  handshake        payload
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
// in_i      in   valid / ready    data_byte
// out_o     out  valid / ready    kind, column, value_byte, column_end, record_end,
//                                 record_kind, record_number
//
// One byte request per clock while in_i.ready is high; each byte updates the parse
// state and yields at most one result, held in a single output register the next cycle.
// in_i.ready is high while the output register is empty or being drained, so a
// held result that out_o does not take blocks in_i in that same cycle.
// Reset (rst_ni, async low) returns to header parsing with all counters cleared.
module record_column_deframer #(
  parameter int unsigned COL_CAP = rcd_pkg::COL_CAP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcd_pkg::CFG_W-1:0]     cfg_data_i,
  rcd_in_if.sink                        in_i,
  rcd_out_if.source                     out_o
);

  localparam int unsigned CIW = (COL_CAP > 1) ? $clog2(COL_CAP) : 1;
  localparam int unsigned LW  = $clog2(COL_CAP + 1);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_MARKER = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_LEN_HI = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [CIW-1:0]                  col_q, col_d;
  logic [rcd_pkg::LEN_W-1:0]       left_q, left_d;
  logic [rcd_pkg::RKIND_W-1:0]     rkind_q, rkind_d;
  logic [rcd_pkg::RECNUM_W-1:0]    recs_q, recs_d;
  logic [LW-1:0]                   lim_q, lim_new;
  logic                            cnt_only_q;

  logic                            ovalid_q, ovalid_d;
  logic [rcd_pkg::KIND_W-1:0]      okind_q, okind_d;
  logic [rcd_pkg::COLUMN_W-1:0]    ocol_q, ocol_d;
  logic [rcd_pkg::BYTE_W-1:0]      oval_q, oval_d;
  logic                            ocend_q, ocend_d;
  logic                            orend_q, orend_d;
  logic [rcd_pkg::RKIND_W-1:0]     orkind_q, orkind_d;
  logic [rcd_pkg::RECNUM_W-1:0]    orec_q, orec_d;

  logic                            in_acc, emit;
  logic                            fin;
  logic [rcd_pkg::KIND_W-1:0]      fin_kind;
  logic [rcd_pkg::BYTE_W-1:0]      fin_val;
  logic [LW-1:0]                   col_plus;
  logic                            rec_end;
  logic [rcd_pkg::BYTE_W-1:0]      b;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign col_plus   = LW'(col_q) + LW'(1);
  assign rec_end    = col_plus >= lim_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      lim_new = LW'(1);
    end else if (32'(cfg_data_i) > 32'(COL_CAP)) begin
      lim_new = LW'(COL_CAP);
    end else begin
      lim_new = LW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q      <= LW'(1);
      cnt_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcd_pkg::REG_RECORD_COLUMNS: lim_q      <= lim_new;
        rcd_pkg::REG_COUNT_ONLY:     cnt_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d  = phase_q;
    col_d    = col_q;
    left_d   = left_q;
    rkind_d  = rkind_q;
    recs_d   = recs_q;
    emit     = 1'b0;
    fin      = 1'b0;
    fin_kind = rcd_pkg::KIND_DATA;
    fin_val  = '0;
    okind_d  = rcd_pkg::KIND_DATA;
    ocol_d   = rcd_pkg::COLUMN_W'(col_q);
    oval_d   = '0;
    ocend_d  = 1'b0;
    orend_d  = 1'b0;
    orkind_d = rkind_q;
    orec_d   = recs_q;

    case (phase_q)
      PH_MARKER: begin
        if (b == rcd_pkg::MRK_NULL) begin
          fin      = 1'b1;
          fin_kind = rcd_pkg::KIND_NULL;
        end else if (b == rcd_pkg::MRK_EMPTY) begin
          fin      = 1'b1;
          fin_kind = rcd_pkg::KIND_EMPTY;
        end else if (b == rcd_pkg::MRK_LEN2) begin
          phase_d = PH_LEN_LO;
        end else begin
          left_d  = rcd_pkg::LEN_W'(b);
          phase_d = PH_DATA;
        end
      end
      PH_LEN_LO: begin
        left_d  = rcd_pkg::LEN_W'(b);
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        left_d  = {b, left_q[7:0]};
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        if (left_q == '0) begin
          fin      = 1'b1;
          fin_kind = rcd_pkg::KIND_EMPTY;
        end else begin
          left_d = left_q - rcd_pkg::LEN_W'(1);
          if (left_q == rcd_pkg::LEN_W'(1)) begin
            fin      = 1'b1;
            fin_kind = rcd_pkg::KIND_DATA;
            fin_val  = b;
          end else begin
            emit   = !cnt_only_q;
            oval_d = b;
          end
        end
      end
      PH_HEADER: begin
        case (b)
          rcd_pkg::HDR_EOT0, rcd_pkg::HDR_EOT1: begin
            emit     = 1'b1;
            okind_d  = rcd_pkg::KIND_EOT;
            ocol_d   = '0;
            orkind_d = rcd_pkg::RKIND_NORMAL;
            recs_d   = '0;
            col_d    = '0;
            left_d   = '0;
            rkind_d  = rcd_pkg::RKIND_NORMAL;
          end
          rcd_pkg::HDR_NORMAL0, rcd_pkg::HDR_NORMAL1: begin
            rkind_d = rcd_pkg::RKIND_NORMAL;
            phase_d = PH_MARKER;
          end
          rcd_pkg::HDR_LOB0, rcd_pkg::HDR_LOB1: begin
            rkind_d = rcd_pkg::RKIND_LOB;
            phase_d = PH_MARKER;
          end
          rcd_pkg::HDR_WIDE0, rcd_pkg::HDR_WIDE1, rcd_pkg::HDR_WIDE2,
          rcd_pkg::HDR_WIDE3, rcd_pkg::HDR_WIDE4: begin
            rkind_d = rcd_pkg::RKIND_WIDE;
            phase_d = PH_MARKER;
          end
          rcd_pkg::HDR_SINGLE: begin
            rkind_d = rcd_pkg::RKIND_SINGLE;
            phase_d = PH_MARKER;
          end
          default: ;
        endcase
        if (phase_d == PH_MARKER) begin
          col_d  = '0;
          left_d = '0;
        end
      end
      default: phase_d = PH_HEADER;
    endcase

    if (fin) begin
      emit    = !cnt_only_q || rec_end;
      okind_d = fin_kind;
      oval_d  = fin_val;
      ocend_d = 1'b1;
      orend_d = rec_end;
      if (rec_end) begin
        if (recs_q != rcd_pkg::RECNUM_MAX) begin
          recs_d = recs_q + rcd_pkg::RECNUM_W'(1);
        end
        phase_d = PH_HEADER;
        col_d   = '0;
      end else begin
        col_d   = CIW'(col_plus);
        phase_d = PH_MARKER;
      end
    end
  end

  assign ovalid_d = (in_acc && emit) || (ovalid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      col_q    <= '0;
      left_q   <= '0;
      rkind_q  <= rcd_pkg::RKIND_NORMAL;
      recs_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (in_acc) begin
        phase_q <= phase_d;
        col_q   <= col_d;
        left_q  <= left_d;
        rkind_q <= rkind_d;
        recs_q  <= recs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      okind_q  <= okind_d;
      ocol_q   <= ocol_d;
      oval_q   <= oval_d;
      ocend_q  <= ocend_d;
      orend_q  <= orend_d;
      orkind_q <= orkind_d;
      orec_q   <= orec_d;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.kind          = okind_q;
  assign out_o.column        = ocol_q;
  assign out_o.value_byte    = oval_q;
  assign out_o.column_end    = ocend_q;
  assign out_o.record_end    = orend_q;
  assign out_o.record_kind   = orkind_q;
  assign out_o.record_number = orec_q;

`ifndef ASSERT_OFF
  a_cnt_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit && cnt_only_q |=> out_o.record_end || out_o.kind == rcd_pkg::KIND_EOT)
    else $error("count-only mode produced a plain column result");

  a_eot_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == rcd_pkg::KIND_EOT |-> !out_o.column_end && !out_o.record_end)
    else $error("end-of-table result carries column flags");

  a_recs_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q != PH_HEADER |=> recs_q >= $past(recs_q))
    else $error("record counter went backwards");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_HEADER |-> LW'(col_q) < lim_q || $past(cfg_we_i))
    else $error("column index beyond record column count");
`endif

endmodule

FILE: tb/rcd_result_checker.sv
`timescale 1ns / 100ps

module rcd_result_checker #(
  parameter int unsigned COL_CAP = rcd_pkg::COL_CAP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcd_pkg::CFG_W-1:0]     cfg_data_i,
  rcd_in_if                             in_mon,
  rcd_out_if                            out_mon,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output logic                          at_header_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_MARKER,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA
  } parse_phase_e;

  typedef struct packed {
    logic [rcd_pkg::KIND_W-1:0]   kind;
    logic [rcd_pkg::COLUMN_W-1:0] column;
    logic [rcd_pkg::BYTE_W-1:0]   value_byte;
    logic                         column_end;
    logic                         record_end;
    logic [rcd_pkg::RKIND_W-1:0]  record_kind;
    logic [rcd_pkg::RECNUM_W-1:0] record_number;
  } column_result_t;

  column_result_t expected_results[$];
  int unsigned    mismatches;

  // register copies
  logic [rcd_pkg::CFG_W-1:0]    rec_cols;
  logic                         count_only;

  // parse state
  parse_phase_e                 phase;
  logic [rcd_pkg::CFG_W-1:0]    col_idx;
  logic [rcd_pkg::LEN_W-1:0]    bytes_left;
  logic [rcd_pkg::RKIND_W-1:0]  rec_kind;
  logic [rcd_pkg::RECNUM_W-1:0] records_done;

  assign fail_count_o = mismatches;

  function automatic logic [rcd_pkg::CFG_W-1:0] col_limit();
    logic [rcd_pkg::CFG_W-1:0] n;
    n = rec_cols;
    if (n == 0) n = rcd_pkg::CFG_W'(1);
    if (32'(n) > COL_CAP) n = rcd_pkg::CFG_W'(COL_CAP);
    return n;
  endfunction

  function automatic void queue_result(logic [rcd_pkg::KIND_W-1:0] k,
                                       logic [rcd_pkg::BYTE_W-1:0] v,
                                       logic col_end, logic rec_end);
    column_result_t r;
    r.kind          = k;
    r.column        = col_idx[rcd_pkg::COLUMN_W-1:0];
    r.value_byte    = v;
    r.column_end    = col_end;
    r.record_end    = rec_end;
    r.record_kind   = rec_kind;
    r.record_number = records_done;
    expected_results.push_back(r);
  endfunction

  function automatic void close_column(logic [rcd_pkg::KIND_W-1:0] k,
                                       logic [rcd_pkg::BYTE_W-1:0] v);
    logic last;
    last = (32'(col_idx) + 1) >= 32'(col_limit());
    if (!count_only || last) queue_result(k, v, 1'b1, last);
    if (last) begin
      if (records_done != rcd_pkg::RECNUM_MAX) records_done++;
      phase   = PH_HEADER;
      col_idx = '0;
    end else begin
      col_idx++;
      phase = PH_MARKER;
    end
  endfunction

  function automatic void open_record(logic [rcd_pkg::RKIND_W-1:0] k);
    rec_kind   = k;
    col_idx    = '0;
    bytes_left = '0;
    phase      = PH_MARKER;
  endfunction

  function automatic void parse_byte(logic [rcd_pkg::BYTE_W-1:0] b);
    column_result_t r;
    case (phase)
      PH_MARKER: begin
        if (b == rcd_pkg::MRK_NULL) close_column(rcd_pkg::KIND_NULL, '0);
        else if (b == rcd_pkg::MRK_EMPTY) close_column(rcd_pkg::KIND_EMPTY, '0);
        else if (b == rcd_pkg::MRK_LEN2) phase = PH_LEN_LO;
        else begin
          bytes_left = {8'h00, b};
          phase      = PH_DATA;
        end
      end
      PH_LEN_LO: begin
        bytes_left = {8'h00, b};
        phase      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left = {b, bytes_left[7:0]};
        phase      = PH_DATA;
      end
      PH_DATA: begin
        if (bytes_left == 0) close_column(rcd_pkg::KIND_EMPTY, '0);
        else begin
          bytes_left--;
          if (bytes_left == 0) close_column(rcd_pkg::KIND_DATA, b);
          else if (!count_only) queue_result(rcd_pkg::KIND_DATA, b, 1'b0, 1'b0);
        end
      end
      default: begin
        phase = PH_HEADER;
        case (b)
          rcd_pkg::HDR_EOT0, rcd_pkg::HDR_EOT1: begin
            r               = '0;
            r.kind          = rcd_pkg::KIND_EOT;
            r.record_number = records_done;
            expected_results.push_back(r);
            records_done = '0;
            col_idx      = '0;
            bytes_left   = '0;
            rec_kind     = rcd_pkg::RKIND_NORMAL;
          end
          rcd_pkg::HDR_NORMAL0, rcd_pkg::HDR_NORMAL1: open_record(rcd_pkg::RKIND_NORMAL);
          rcd_pkg::HDR_LOB0, rcd_pkg::HDR_LOB1:       open_record(rcd_pkg::RKIND_LOB);
          rcd_pkg::HDR_WIDE0, rcd_pkg::HDR_WIDE1, rcd_pkg::HDR_WIDE2,
          rcd_pkg::HDR_WIDE3, rcd_pkg::HDR_WIDE4:     open_record(rcd_pkg::RKIND_WIDE);
          rcd_pkg::HDR_SINGLE:                        open_record(rcd_pkg::RKIND_SINGLE);
          default: ;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    column_result_t got;
    column_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      rec_cols     = rcd_pkg::CFG_W'(1);
      count_only   = 1'b0;
      phase        = PH_HEADER;
      col_idx      = '0;
      bytes_left   = '0;
      rec_kind     = rcd_pkg::RKIND_NORMAL;
      records_done = '0;
      pending_o   <= 0;
      at_header_o <= 1'b1;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.kind, out_mon.column, out_mon.value_byte, out_mon.column_end,
               out_mon.record_end, out_mon.record_kind, out_mon.record_number};
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, kind", 32'(got.kind), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
          if (got.column !== want.column)
            report_mismatch("column", 32'(got.column), 32'(want.column));
          if (got.value_byte !== want.value_byte)
            report_mismatch("value_byte", 32'(got.value_byte), 32'(want.value_byte));
          if (got.column_end !== want.column_end)
            report_mismatch("column_end", 32'(got.column_end), 32'(want.column_end));
          if (got.record_end !== want.record_end)
            report_mismatch("record_end", 32'(got.record_end), 32'(want.record_end));
          if (got.record_kind !== want.record_kind)
            report_mismatch("record_kind", 32'(got.record_kind), 32'(want.record_kind));
          if (got.record_number !== want.record_number)
            report_mismatch("record_number", got.record_number, want.record_number);
        end
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data_byte);
      if (cfg_we_i) begin
        if (cfg_idx_i == rcd_pkg::REG_RECORD_COLUMNS) rec_cols = cfg_data_i;
        else if (cfg_idx_i == rcd_pkg::REG_COUNT_ONLY) count_only = cfg_data_i[0];
      end
      pending_o   <= expected_results.size();
      at_header_o <= (phase == PH_HEADER);
    end
  end

endmodule

FILE: tb/tb_record_column_deframer.sv
`timescale 1ns / 100ps

module tb_record_column_deframer;

  localparam logic [rcd_pkg::BYTE_W-1:0] OPENING_SEQ [24] = '{
    8'h02, rcd_pkg::HDR_NORMAL1, rcd_pkg::MRK_EMPTY, rcd_pkg::MRK_NULL,
    8'h02, 8'h00, 8'hFF,
    rcd_pkg::HDR_LOB1, rcd_pkg::MRK_LEN2, 8'h00, 8'h00, 8'h5A,
    rcd_pkg::MRK_LEN2, 8'h01, 8'h00, 8'h80,
    8'h01, 8'h7F, rcd_pkg::HDR_EOT0,
    rcd_pkg::HDR_WIDE4, rcd_pkg::MRK_NULL, rcd_pkg::MRK_NULL, rcd_pkg::MRK_NULL,
    rcd_pkg::HDR_EOT1
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [rcd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [rcd_pkg::CFG_W-1:0]     cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  logic        at_header;

  int src_idle_pct;
  int sink_stall_pct;
  int hold_cycles;
  int sent;
  int eff_cols;

  rcd_in_if  in_ch ();
  rcd_out_if out_ch ();

  record_column_deframer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  rcd_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .at_header_o  (at_header)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [rcd_pkg::BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcd_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input int rc, input int co, input int src, input int sink);
    quiesce();
    write_reg(rcd_pkg::REG_RECORD_COLUMNS, rcd_pkg::CFG_W'(rc));
    write_reg(rcd_pkg::REG_COUNT_ONLY, rcd_pkg::CFG_W'(co));
    eff_cols       = (rc == 0) ? 1 :
                     ((rc > int'(rcd_pkg::COL_CAP_DEF)) ? int'(rcd_pkg::COL_CAP_DEF) : rc);
    src_idle_pct   = src;
    sink_stall_pct = sink;
  endtask

  function automatic logic [rcd_pkg::BYTE_W-1:0] pick_header();
    case ($urandom_range(0, 9))
      0:       return rcd_pkg::HDR_NORMAL0;
      1:       return rcd_pkg::HDR_NORMAL1;
      2:       return rcd_pkg::HDR_LOB0;
      3:       return rcd_pkg::HDR_LOB1;
      4:       return rcd_pkg::HDR_WIDE0;
      5:       return rcd_pkg::HDR_WIDE1;
      6:       return rcd_pkg::HDR_WIDE2;
      7:       return rcd_pkg::HDR_WIDE3;
      8:       return rcd_pkg::HDR_WIDE4;
      default: return rcd_pkg::HDR_SINGLE;
    endcase
  endfunction

  // no two-byte length marker, so a stray length stays short
  function automatic logic [rcd_pkg::BYTE_W-1:0] noise_byte();
    logic [rcd_pkg::BYTE_W-1:0] b;
    b = rcd_pkg::BYTE_W'($urandom_range(0, 255));
    if (b == rcd_pkg::MRK_LEN2) b = ~b;
    return b;
  endfunction

  task automatic send_column();
    int t;
    int len;
    t = $urandom_range(0, 99);
    if (t < 15) begin
      send_byte(rcd_pkg::MRK_NULL);
    end else if (t < 30) begin
      send_byte(rcd_pkg::MRK_EMPTY);
    end else if (t < 75) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 253) : $urandom_range(1, 8);
      send_byte(rcd_pkg::BYTE_W'(len));
      repeat (len) send_byte(rcd_pkg::BYTE_W'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 99) == 0) ? 256 + $urandom_range(0, 3) : $urandom_range(0, 6);
      send_byte(rcd_pkg::MRK_LEN2);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (len == 0) send_byte(rcd_pkg::BYTE_W'($urandom_range(0, 255)));
      else repeat (len) send_byte(rcd_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // nulls close any open columns and records; at_header lags one request
  task automatic resync();
    do send_byte(rcd_pkg::MRK_NULL); while (!at_header);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int r;
    int cols;
    stop_at = sent + count;
    while (sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_byte(pick_header());
        repeat (eff_cols) send_column();
      end else if (r < 83) begin
        cols = $urandom_range(0, eff_cols - 1);
        send_byte(pick_header());
        repeat (cols) send_column();
        repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        resync();
      end else if (r < 92) begin
        repeat ($urandom_range(1, 6)) send_byte(noise_byte());
        resync();
      end else begin
        send_byte($urandom_range(0, 1) ? rcd_pkg::HDR_EOT0 : rcd_pkg::HDR_EOT1);
      end
    end
  endtask

  task automatic full_width_record();
    send_byte(rcd_pkg::HDR_WIDE0);
    repeat (eff_cols) begin
      if ($urandom_range(0, 127) == 0) send_column();
      else send_byte($urandom_range(0, 1) ? rcd_pkg::MRK_NULL : rcd_pkg::MRK_EMPTY);
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = rcd_pkg::REG_RECORD_COLUMNS;
    cfg_data_i      = '0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_cycles     = 0;
    sent            = 0;
    eff_cols        = 1;
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(3, 0, 0, 0);
    foreach (OPENING_SEQ[i]) send_byte(OPENING_SEQ[i]);

    configure(0, 1, 8, 8);
    random_traffic(40);
    configure(5, 0, 63, 0);
    random_traffic(40);
    configure(2, 0, 0, 63);
    hold_cycles = 300;
    random_traffic(40);
    configure(7, 1, 8, 8);
    random_traffic(40);
    configure(1, 0, 0, 0);
    random_traffic(40);
    configure(4, 0, 63, 63);
    random_traffic(40);

    configure(2047, 0, 8, 8);
    full_width_record();
    send_byte(rcd_pkg::HDR_EOT0);

    quiesce();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
